// File: rtl/pva_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pva_pkg
// shared types and constants of the priority voice allocator
// ----------------------------------------------------------------------------
package pva_pkg;

  // field widths
  localparam int ACT_W = 2;
  localparam int CH_W  = 7;
  localparam int PRI_W = 8;

  // request codes
  localparam logic [ACT_W-1:0] ACT_PLAY   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SETPRI = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FINISH = 2'd2;
  localparam logic [ACT_W-1:0] ACT_TICK   = 2'd3;

  // running minimum starts above every real priority
  localparam logic [PRI_W:0] PRI_NONE = 9'h100;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } pva_state_t;

  typedef struct packed {
    logic capture;
    logic scan_step;
    logic commit;
  } pva_cmd_t;

  typedef struct packed {
    logic auto_play;
    logic scan_done;
  } pva_sts_t;

endpackage

// File: rtl/pva_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pva_dp
// channel table, slot scan and result register
// ----------------------------------------------------------------------------
module pva_dp #(
  parameter int CHANNELS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  pva_pkg::pva_cmd_t              cmd,
  output pva_pkg::pva_sts_t              sts,
  input  logic [pva_pkg::ACT_W-1:0]      action,
  input  logic signed [pva_pkg::CH_W-1:0] requested_channel,
  input  logic [pva_pkg::PRI_W-1:0]      priority_req,
  output logic signed [pva_pkg::CH_W-1:0] granted_channel,
  output logic                           replaced,
  output logic                           accepted
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(CHANNELS - 1);

  // captured request
  logic [pva_pkg::ACT_W-1:0] req_action;
  logic [pva_pkg::CH_W-1:0]  req_ch;
  logic [pva_pkg::PRI_W-1:0] req_prio;

  // channel table
  logic [CHANNELS-1:0]       busy;
  logic [CHANNELS-1:0]       pending;
  logic [pva_pkg::PRI_W-1:0] prio_mem [CHANNELS];

  // scan
  logic [IDX_W-1:0]          scan_idx;
  logic                      issue_more;
  logic [IDX_W-1:0]          cmp_idx;
  logic                      cmp_valid;
  logic [pva_pkg::PRI_W-1:0] prio_q;
  logic [pva_pkg::PRI_W:0]   low_pri;
  logic [IDX_W-1:0]          low_idx;
  logic                      pick_free;
  logic [IDX_W-1:0]          pick_idx;

  // commit decode
  logic [IDX_W-1:0] ch_idx;
  logic             in_range;
  logic             auto_ok;
  logic [IDX_W-1:0] auto_idx;
  logic [IDX_W-1:0] sel;
  logic             ok;
  logic             set_busy;
  logic             wr_pri;
  logic             set_pend;
  logic             tick;
  logic             cmp_busy;

  assign sts.auto_play = (action == pva_pkg::ACT_PLAY) && requested_channel[pva_pkg::CH_W-1];

  assign cmp_busy      = busy[cmp_idx];
  assign sts.scan_done = cmp_valid && (!cmp_busy || (cmp_idx == LAST));

  assign ch_idx   = req_ch[IDX_W-1:0];
  assign in_range = !req_ch[pva_pkg::CH_W-1] &&
                    ({1'b0, req_ch[pva_pkg::CH_W-2:0]} < pva_pkg::CH_W'(CHANNELS));
  assign auto_ok  = pick_free || (low_pri < {1'b0, req_prio});
  assign auto_idx = pick_free ? pick_idx : low_idx;

  always_comb begin
    ok       = 1'b0;
    sel      = ch_idx;
    set_busy = 1'b0;
    wr_pri   = 1'b0;
    set_pend = 1'b0;
    tick     = 1'b0;
    case (req_action)
      pva_pkg::ACT_PLAY: begin
        if (req_ch[pva_pkg::CH_W-1]) begin
          sel = auto_idx;
          ok  = auto_ok;
        end else begin
          ok = in_range;
        end
        set_busy = ok;
        wr_pri   = ok;
      end
      pva_pkg::ACT_SETPRI: begin
        ok     = in_range && busy[ch_idx];
        wr_pri = ok;
      end
      pva_pkg::ACT_FINISH: begin
        ok       = in_range;
        set_pend = ok;
      end
      pva_pkg::ACT_TICK: begin
        ok   = 1'b1;
        tick = 1'b1;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_action <= action;
      req_ch     <= requested_channel;
      req_prio   <= priority_req;
    end
  end

  // occupied and release marks
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= '0;
      pending <= '0;
    end else if (cmd.commit) begin
      if (tick) begin
        busy    <= busy & ~pending;
        pending <= '0;
      end else begin
        if (set_busy) begin
          busy[sel] <= 1'b1;
        end
        if (set_pend) begin
          pending[ch_idx] <= 1'b1;
        end
      end
    end
  end

  // priority memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.commit && wr_pri) begin
      prio_mem[sel] <= req_prio;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && issue_more) begin
      prio_q <= prio_mem[scan_idx];
    end
  end

  // slot scan: read stage then compare stage
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_more <= 1'b0;
      cmp_valid  <= 1'b0;
      pick_free  <= 1'b0;
      scan_idx   <= '0;
      low_pri    <= pva_pkg::PRI_NONE;
    end else if (cmd.capture) begin
      issue_more <= 1'b1;
      cmp_valid  <= 1'b0;
      pick_free  <= 1'b0;
      scan_idx   <= '0;
      low_pri    <= pva_pkg::PRI_NONE;
    end else if (cmd.scan_step) begin
      cmp_valid <= issue_more;
      if (issue_more) begin
        cmp_idx <= scan_idx;
        if (scan_idx == LAST) begin
          issue_more <= 1'b0;
        end else begin
          scan_idx <= scan_idx + 1'b1;
        end
      end
      if (cmp_valid && !pick_free) begin
        if (!cmp_busy) begin
          pick_free <= 1'b1;
          pick_idx  <= cmp_idx;
        end else if ({1'b0, prio_q} < low_pri) begin
          low_pri <= {1'b0, prio_q};
          low_idx <= cmp_idx;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      accepted <= ok;
      if ((req_action == pva_pkg::ACT_PLAY) && ok) begin
        granted_channel <= pva_pkg::CH_W'(sel);
        replaced        <= busy[sel];
      end else begin
        granted_channel <= '1;
        replaced        <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/pva_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pva_ctrl
// sequencer and handshake control of the priority voice allocator
// ----------------------------------------------------------------------------
module pva_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  pva_pkg::pva_sts_t     sts,
  output pva_pkg::pva_cmd_t     cmd
);

  pva_pkg::pva_state_t state;
  pva_pkg::pva_state_t state_next;
  logic                out_valid_next;
  logic                out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pva_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    cmd            = '0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      pva_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = sts.auto_play ? pva_pkg::ST_SCAN : pva_pkg::ST_COMMIT;
        end
      end
      pva_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_next = pva_pkg::ST_COMMIT;
        end
      end
      pva_pkg::ST_COMMIT: begin
        if (out_free) begin
          cmd.commit     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = pva_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pva_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/priority_voice_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_voice_allocator
// playback channel allocator with lowest-priority voice stealing
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+--------------------------------------------
//  in      | in_valid / in_ready | action, requested_channel, priority_req
//  out     | out_valid/out_ready | granted_channel, replaced, accepted
//
//  explicit requests (set priority, finished, tick, play on a named channel)
//  go through capture, then commit into the table and result register
//  automatic play scans the table one slot a cycle through the priority
//  memory read port between capture and commit, stopping at the first
//  free slot or after the last slot
//  reset clears the occupied and release marks at once; no clearing pass
//  a waiting result does not block the next request; only the commit of
//  that request waits for the result register to empty
// ----------------------------------------------------------------------------
module priority_voice_allocator #(
  parameter int CHANNELS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [pva_pkg::ACT_W-1:0]       action,
  input  logic signed [pva_pkg::CH_W-1:0] requested_channel,
  input  logic [pva_pkg::PRI_W-1:0]       priority_req,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [pva_pkg::CH_W-1:0] granted_channel,
  output logic                            replaced,
  output logic                            accepted
);

  // command and status between sequencer and datapath
  pva_pkg::pva_cmd_t cmd;
  pva_pkg::pva_sts_t sts;

  // sequencer: owns both handshakes
  pva_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: channel table, priority memory, scan and result register
  pva_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .action            (action),
    .requested_channel (requested_channel),
    .priority_req      (priority_req),
    .granted_channel   (granted_channel),
    .replaced          (replaced),
    .accepted          (accepted)
  );

endmodule
